// ===== rtl/wld_pkg.sv =====
// Shared constants for the wire length and direction core.
package wld_pkg;
    localparam int COORD_W  = 32;
    localparam int COUNT_W  = 10;
    localparam int LEN_W    = 33;
    localparam int DIR_W    = 18;
    localparam int STAT_W   = 2;
    localparam int IN_W     = 6 * COORD_W + COUNT_W;
    localparam int IN_BYTES = (IN_W + 7) / 8;
    localparam int OUT_W    = 2 * LEN_W + 3 * DIR_W;
    localparam int OUT_BYTES = (OUT_W + 7) / 8;
    localparam int ROOT_STAGES = 33;
    localparam int DIV_STAGES  = 33;
    localparam int COS_BITS    = 17;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_ZERO_LEN = 2'd1,
        STAT_ZERO_SEG = 2'd2
    } t_status;
endpackage

// ===== rtl/wire_length_and_direction_core.sv =====
// Top level: streaming wire length, segment length and direction cosine pipeline.
// Each word carries the two Q16.16 end points of a straight wire and its segment count;
// the core returns the floored Euclidean length (Q16.16), the length divided by the
// segment count (Q16.16, truncated) and the three direction cosines (Q1.16, truncated
// toward zero). A new word can be taken every cycle unless the output stalls. The
// pipeline registers the difference, the partial products, and the squares and their
// sum, then runs the one-bit-per-stage square root, the shared division stages (segment
// divider and the three cosine dividers run side by side) and one output register. The
// whole pipeline advances together; it holds while a finished word waits at the output.
// A coincident pair of end points reports status 1 with all fields zero, a zero segment
// count status 2 with a zero segment length.
module wire_length_and_direction_core #(
    parameter int SEGMENT_BITS = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // end1_x, end1_y, end1_z, end2_x, end2_y, end2_z, segment_count, zero fill
    input  logic [wld_pkg::IN_BYTES*8-1:0]  i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // wire_length, segment_length, dir_x, dir_y, dir_z
    output logic [wld_pkg::OUT_BYTES*8-1:0] o_m_tdata,
    // status
    output logic [wld_pkg::STAT_W-1:0]      o_m_tuser
);
    import wld_pkg::*;

    localparam int SB = SEGMENT_BITS;

    // side data that rides along the root stages
    typedef struct packed {
        logic [COORD_W-1:0] ax;
        logic [COORD_W-1:0] ay;
        logic [COORD_W-1:0] az;
        logic [2:0]         sgn;
        logic [SB-1:0]      segs;
    } t_side;

    typedef struct packed {
        logic [2*LEN_W-1:0] rad;
        logic [LEN_W+1:0]   rem;
        logic [LEN_W-1:0]   root;
        t_side              side;
    } t_root;

    typedef struct packed {
        logic [LEN_W-1:0]   len;
        logic [LEN_W-1:0]   sq;
        logic [SB-1:0]      srem;
        logic [LEN_W-1:0]   crem0;
        logic [LEN_W-1:0]   crem1;
        logic [LEN_W-1:0]   crem2;
        logic [COS_BITS-1:0] cq0;
        logic [COS_BITS-1:0] cq1;
        logic [COS_BITS-1:0] cq2;
        logic [2:0]         lsb;
        logic [2:0]         sgn;
        logic [SB-1:0]      segs;
    } t_div;

    logic en;
    assign en         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;

    // ---- stage A: differences and magnitudes
    logic [SB-1:0] segs_in;
    generate
        if (SB >= COUNT_W) begin : g_segw
            assign segs_in = SB'(i_s_tdata[6*COORD_W +: COUNT_W]);
        end else begin : g_segn
            assign segs_in = i_s_tdata[6*COORD_W +: SB];
        end
    endgenerate

    logic [COORD_W:0]   d_c [3];
    logic [COORD_W-1:0] a_c [3];
    logic [2:0]         s_c;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d_c[i] = {i_s_tdata[(i+3)*COORD_W + COORD_W-1], i_s_tdata[(i+3)*COORD_W +: COORD_W]}
                   - {i_s_tdata[i*COORD_W + COORD_W-1], i_s_tdata[i*COORD_W +: COORD_W]};
            s_c[i] = d_c[i][COORD_W];
            a_c[i] = s_c[i] ? COORD_W'(-d_c[i]) : d_c[i][COORD_W-1:0];
        end
    end

    logic  r_a_v;
    t_side r_a;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (en) begin
            r_a_v <= i_s_tvalid;
        end
        if (en) begin
            r_a.ax   <= a_c[0];
            r_a.ay   <= a_c[1];
            r_a.az   <= a_c[2];
            r_a.sgn  <= s_c;
            r_a.segs <= segs_in;
        end
    end

    // ---- stage B: 16x16 partial products
    logic  r_b_v;
    t_side r_b;
    logic [31:0] r_hh [3];
    logic [31:0] r_hl [3];
    logic [31:0] r_ll [3];
    logic [COORD_W-1:0] a_b [3];
    assign a_b[0] = r_a.ax;
    assign a_b[1] = r_a.ay;
    assign a_b[2] = r_a.az;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (en) begin
            r_b_v <= r_a_v;
        end
        if (en) begin
            r_b <= r_a;
            for (int i = 0; i < 3; i++) begin
                r_hh[i] <= a_b[i][31:16] * a_b[i][31:16];
                r_hl[i] <= a_b[i][31:16] * a_b[i][15:0];
                r_ll[i] <= a_b[i][15:0]  * a_b[i][15:0];
            end
        end
    end

    // ---- stage C: squares
    logic  r_c_v;
    t_side r_c;
    logic [63:0] r_sqr [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (en) begin
            r_c_v <= r_b_v;
        end
        if (en) begin
            r_c <= r_b;
            for (int i = 0; i < 3; i++) begin
                r_sqr[i] <= {r_hh[i], 32'd0} + {15'd0, r_hl[i], 17'd0} + {32'd0, r_ll[i]};
            end
        end
    end

    // ---- stage D: sum of squares, enters the root chain
    logic  r_rt_v [ROOT_STAGES+1];
    t_root r_rt   [ROOT_STAGES+1];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rt_v[0] <= 1'b0;
        end else if (en) begin
            r_rt_v[0] <= r_c_v;
        end
        if (en) begin
            r_rt[0].rad  <= {2'd0, r_sqr[0]} + {2'd0, r_sqr[1]} + {2'd0, r_sqr[2]};
            r_rt[0].rem  <= '0;
            r_rt[0].root <= '0;
            r_rt[0].side <= r_c;
        end
    end

    // ---- square root, one result bit a stage
    generate
        for (genvar k = 0; k < ROOT_STAGES; k++) begin : g_root
            logic [LEN_W+1:0] sh, trial;
            always_comb begin
                sh    = {r_rt[k].rem[LEN_W-1:0], r_rt[k].rad[2*LEN_W-1 -: 2]};
                trial = {r_rt[k].root, 2'b01};
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_rt_v[k+1] <= 1'b0;
                end else if (en) begin
                    r_rt_v[k+1] <= r_rt_v[k];
                end
                if (en) begin
                    r_rt[k+1].rad  <= {r_rt[k].rad[2*LEN_W-3:0], 2'b00};
                    r_rt[k+1].side <= r_rt[k].side;
                    if (sh >= trial) begin
                        r_rt[k+1].rem  <= sh - trial;
                        r_rt[k+1].root <= {r_rt[k].root[LEN_W-2:0], 1'b1};
                    end else begin
                        r_rt[k+1].rem  <= sh;
                        r_rt[k+1].root <= {r_rt[k].root[LEN_W-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    // ---- division chain: segment quotient all stages, cosines in the last 17
    logic r_dv_v [DIV_STAGES+1];
    t_div r_dv   [DIV_STAGES+1];
    t_root rl;
    assign rl = r_rt[ROOT_STAGES];
    always_comb begin
        r_dv_v[0]       = r_rt_v[ROOT_STAGES];
        r_dv[0].len     = rl.root;
        r_dv[0].sq      = '0;
        r_dv[0].srem    = '0;
        r_dv[0].crem0   = {2'b00, rl.side.ax[COORD_W-1:1]};
        r_dv[0].crem1   = {2'b00, rl.side.ay[COORD_W-1:1]};
        r_dv[0].crem2   = {2'b00, rl.side.az[COORD_W-1:1]};
        r_dv[0].cq0     = '0;
        r_dv[0].cq1     = '0;
        r_dv[0].cq2     = '0;
        r_dv[0].lsb     = {rl.side.az[0], rl.side.ay[0], rl.side.ax[0]};
        r_dv[0].sgn     = rl.side.sgn;
        r_dv[0].segs    = rl.side.segs;
    end

    generate
        for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
            localparam bit COS_ON = (j >= DIV_STAGES - COS_BITS);
            localparam bit COS_FIRST = (j == DIV_STAGES - COS_BITS);
            logic [SB:0]    ssh;
            logic [LEN_W:0] csh [3];
            logic [LEN_W-1:0] crem [3];
            logic [2:0]     cin;
            always_comb begin
                ssh     = {r_dv[j].srem, r_dv[j].len[LEN_W-1-j]};
                crem[0] = r_dv[j].crem0;
                crem[1] = r_dv[j].crem1;
                crem[2] = r_dv[j].crem2;
                cin     = COS_FIRST ? r_dv[j].lsb : 3'b000;
                for (int i = 0; i < 3; i++) begin
                    csh[i] = {crem[i], cin[i]};
                end
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dv_v[j+1] <= 1'b0;
                end else if (en) begin
                    r_dv_v[j+1] <= r_dv_v[j];
                end
                if (en) begin
                    r_dv[j+1].len  <= r_dv[j].len;
                    r_dv[j+1].lsb  <= r_dv[j].lsb;
                    r_dv[j+1].sgn  <= r_dv[j].sgn;
                    r_dv[j+1].segs <= r_dv[j].segs;
                    if (ssh >= {1'b0, r_dv[j].segs}) begin
                        r_dv[j+1].srem <= SB'(ssh - {1'b0, r_dv[j].segs});
                        r_dv[j+1].sq   <= {r_dv[j].sq[LEN_W-2:0], 1'b1};
                    end else begin
                        r_dv[j+1].srem <= ssh[SB-1:0];
                        r_dv[j+1].sq   <= {r_dv[j].sq[LEN_W-2:0], 1'b0};
                    end
                    if (COS_ON) begin
                        if (csh[0] >= {1'b0, r_dv[j].len}) begin
                            r_dv[j+1].crem0 <= LEN_W'(csh[0] - {1'b0, r_dv[j].len});
                            r_dv[j+1].cq0   <= {r_dv[j].cq0[COS_BITS-2:0], 1'b1};
                        end else begin
                            r_dv[j+1].crem0 <= csh[0][LEN_W-1:0];
                            r_dv[j+1].cq0   <= {r_dv[j].cq0[COS_BITS-2:0], 1'b0};
                        end
                        if (csh[1] >= {1'b0, r_dv[j].len}) begin
                            r_dv[j+1].crem1 <= LEN_W'(csh[1] - {1'b0, r_dv[j].len});
                            r_dv[j+1].cq1   <= {r_dv[j].cq1[COS_BITS-2:0], 1'b1};
                        end else begin
                            r_dv[j+1].crem1 <= csh[1][LEN_W-1:0];
                            r_dv[j+1].cq1   <= {r_dv[j].cq1[COS_BITS-2:0], 1'b0};
                        end
                        if (csh[2] >= {1'b0, r_dv[j].len}) begin
                            r_dv[j+1].crem2 <= LEN_W'(csh[2] - {1'b0, r_dv[j].len});
                            r_dv[j+1].cq2   <= {r_dv[j].cq2[COS_BITS-2:0], 1'b1};
                        end else begin
                            r_dv[j+1].crem2 <= csh[2][LEN_W-1:0];
                            r_dv[j+1].cq2   <= {r_dv[j].cq2[COS_BITS-2:0], 1'b0};
                        end
                    end else begin
                        r_dv[j+1].crem0 <= r_dv[j].crem0;
                        r_dv[j+1].crem1 <= r_dv[j].crem1;
                        r_dv[j+1].crem2 <= r_dv[j].crem2;
                        r_dv[j+1].cq0   <= r_dv[j].cq0;
                        r_dv[j+1].cq1   <= r_dv[j].cq1;
                        r_dv[j+1].cq2   <= r_dv[j].cq2;
                    end
                end
            end
        end
    endgenerate

    // ---- output register: sign, special cases
    t_div df;
    assign df = r_dv[DIV_STAGES];
    logic [DIR_W-1:0] cos_n [3];
    logic [COS_BITS-1:0] cq [3];
    logic zlen, zseg;
    t_status stat_n;
    assign cq[0] = df.cq0;
    assign cq[1] = df.cq1;
    assign cq[2] = df.cq2;
    always_comb begin
        zlen = (df.len == '0);
        zseg = (df.segs == '0);
        for (int i = 0; i < 3; i++) begin
            cos_n[i] = df.sgn[i] ? DIR_W'(-{1'b0, cq[i]}) : {1'b0, cq[i]};
        end
        case ({zlen, zseg})
            2'b00:   stat_n = STAT_OK;
            2'b01:   stat_n = STAT_ZERO_SEG;
            default: stat_n = STAT_ZERO_LEN;
        endcase
    end

    logic r_out_v;
    logic [OUT_W-1:0]  r_out;
    logic [STAT_W-1:0] r_stat;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_dv_v[DIV_STAGES];
        end
        if (en) begin
            r_stat <= stat_n;
            if (zlen) begin
                r_out <= '0;
            end else begin
                r_out <= {cos_n[2], cos_n[1], cos_n[0], zseg ? {LEN_W{1'b0}} : df.sq, df.len};
            end
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = (OUT_BYTES*8)'(r_out);
    assign o_m_tuser  = r_stat;

`ifndef SYNTHESIS
    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == STAT_ZERO_LEN) |-> (o_m_tdata == '0))
        else $error("zero length word carries non-zero fields");
    a_seg_le_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == STAT_OK) |-> (o_m_tdata[65:33] <= o_m_tdata[32:0]))
        else $error("segment length exceeds wire length");
    a_zero_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == STAT_ZERO_SEG) |-> (o_m_tdata[65:33] == '0))
        else $error("zero segment word has segment length");
    a_cos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != STAT_ZERO_LEN) |->
        ($signed(o_m_tdata[83:66]) <= 18'sd65536 &&
         $signed(o_m_tdata[83:66]) >= -18'sd65536))
        else $error("x cosine out of range");
`endif
endmodule

// ===== verif/wld_checker.sv =====
// Checker for the wire length and direction core: predicts each result and compares it.
`timescale 1ns / 100ps
module wld_checker #(
    parameter int SEGMENT_BITS = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    input  logic                                i_s_tready,
    input  logic [wld_pkg::IN_BYTES*8-1:0]      i_s_tdata,
    input  logic                                i_m_tvalid,
    input  logic                                i_m_tready,
    input  logic [wld_pkg::OUT_BYTES*8-1:0]     i_m_tdata,
    input  logic [wld_pkg::STAT_W-1:0]          i_m_tuser,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_seen
);
    import wld_pkg::*;

    typedef struct packed {
        logic [LEN_W-1:0] length;
        logic [LEN_W-1:0] seg_len;
        logic [DIR_W-1:0] dx;
        logic [DIR_W-1:0] dy;
        logic [DIR_W-1:0] dz;
        t_status          stat;
    } t_wire_res;

    t_wire_res wire_q[$];
    int        fails = 0;
    int        seen  = 0;

    assign o_fail_count = fails;
    assign o_pending    = wire_q.size();
    assign o_seen       = seen;

    // floor square root by bit-by-bit trial
    function automatic logic [LEN_W-1:0] root_floor(logic [66:0] s);
        logic [LEN_W-1:0] r;
        logic [LEN_W-1:0] c;
        r = '0;
        for (int b = LEN_W - 1; b >= 0; b--) begin
            c = r | (LEN_W'(1) << b);
            if ({34'd0, c} * {34'd0, c} <= s) r = c;
        end
        return r;
    endfunction

    function automatic logic [DIR_W-1:0] dir_cos(logic signed [33:0] comp,
                                                 logic [LEN_W-1:0] len);
        logic [63:0] mag;
        logic [63:0] q;
        mag = comp < 0 ? 64'(-comp) : 64'(comp);
        q = (mag << 16) / {31'd0, len};
        if (comp < 0) q = -q;
        return q[DIR_W-1:0];
    endfunction

    function automatic t_wire_res wire_predict(logic [IN_BYTES*8-1:0] w);
        logic signed [33:0] d[3];
        logic [33:0]        a;
        logic [66:0]        sum;
        logic [15:0]        segs;
        t_wire_res          r;
        sum = '0;
        for (int k = 0; k < 3; k++) begin
            d[k] = 34'(signed'(w[(k+3)*32 +: 32])) - 34'(signed'(w[k*32 +: 32]));
            a = d[k] < 0 ? -d[k] : d[k];
            sum += {33'd0, a} * {33'd0, a};
        end
        segs = 16'(w[192 +: COUNT_W]) & ((16'd1 << SEGMENT_BITS) - 16'd1);
        r = '0;
        r.length = root_floor(sum);
        if (r.length == 0) begin
            r = '0;
            r.stat = STAT_ZERO_LEN;
            return r;
        end
        r.seg_len = segs != 0 ? r.length / LEN_W'(segs) : '0;
        r.dx = dir_cos(d[0], r.length);
        r.dy = dir_cos(d[1], r.length);
        r.dz = dir_cos(d[2], r.length);
        r.stat = segs != 0 ? STAT_OK : STAT_ZERO_SEG;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_wire_res exp_r;
        t_wire_res got;
        if (i_rst_n && i_s_tvalid && i_s_tready)
            wire_q = {wire_q, wire_predict(i_s_tdata)};
        if (i_rst_n && i_m_tvalid && i_m_tready) begin
            got.length  = i_m_tdata[0 +: LEN_W];
            got.seg_len = i_m_tdata[LEN_W +: LEN_W];
            got.dx      = i_m_tdata[2*LEN_W +: DIR_W];
            got.dy      = i_m_tdata[2*LEN_W+DIR_W +: DIR_W];
            got.dz      = i_m_tdata[2*LEN_W+2*DIR_W +: DIR_W];
            got.stat    = t_status'(i_m_tuser);
            seen++;
            if (wire_q.size() == 0) begin
                fails++;
                if (fails <= 10) $display("unexpected word: %p", got);
            end else begin
                exp_r = wire_q.pop_front();
                if (got !== exp_r) begin
                    fails++;
                    if (fails <= 10)
                        $display("mismatch: expected %p, got %p", exp_r, got);
                end
            end
        end
    end
endmodule

// ===== verif/tb_top.sv =====
// Testbench top: stimulus, idling and the verdict for the wire length and direction core.
`timescale 1ns / 100ps
module tb_top;
    import wld_pkg::*;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [IN_BYTES*8-1:0]    s_data = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [OUT_BYTES*8-1:0]   m_data;
    logic [STAT_W-1:0]        m_user;
    int                       fail_count, pending, seen;
    bit                       idle_on = 1'b1;
    int                       sent = 0;

    always #5 i_clk = ~i_clk;

    wire_length_and_direction_core #(.SEGMENT_BITS(10)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_valid), .o_s_tready(s_ready), .i_s_tdata(s_data),
        .o_m_tvalid(m_valid), .i_m_tready(m_ready), .o_m_tdata(m_data),
        .o_m_tuser(m_user)
    );

    wld_checker #(.SEGMENT_BITS(10)) chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_valid), .i_s_tready(s_ready), .i_s_tdata(s_data),
        .i_m_tvalid(m_valid), .i_m_tready(m_ready), .i_m_tdata(m_data),
        .i_m_tuser(m_user),
        .o_fail_count(fail_count), .o_pending(pending), .o_seen(seen)
    );

    // Receiver: random stall bursts, always ready once idling is off.
    initial begin
        int burst;
        forever begin
            @(posedge i_clk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 19);
                m_ready <= 1'b0;
                repeat (burst) @(posedge i_clk);
            end
            m_ready <= 1'b1;
        end
    end

    // Random coordinate: full range, small values, or extremes.
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return $urandom;
        endcase
    endfunction

    // One word onto the slave side; a random gap may precede it.
    task automatic send_wire(logic [31:0] c[6], logic [COUNT_W-1:0] segs);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_data  <= {c[5], c[4], c[3], c[2], c[1], c[0]} | (IN_BYTES*8)'(segs) << 192;
        s_valid <= 1'b1;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        sent++;
    endtask

    initial begin
        logic [31:0]        c[6];
        logic [COUNT_W-1:0] segs;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, coincident ends, zero segments, both at once, axis wires.
        for (int k = 0; k < 24; k++) begin
            for (int j = 0; j < 6; j++) c[j] = 32'd0;
            segs = COUNT_W'(k % 3 == 0 ? 0 : (k % 3 == 1 ? 1 : 1023));
            case (k / 3)
                0: ;                                      // coincident ends
                1: begin c[0] = 32'h8000_0000; c[3] = 32'h7fff_ffff; end
                2: begin
                    for (int j = 0; j < 3; j++) begin
                        c[j] = 32'h8000_0000; c[j+3] = 32'h7fff_ffff;
                    end
                end
                3: begin
                    for (int j = 0; j < 3; j++) begin
                        c[j] = 32'h7fff_ffff; c[j+3] = 32'h8000_0000;
                    end
                end
                4: c[4] = 32'd1;                          // smallest step
                5: c[5] = 32'hffff_ffff;
                6: begin c[1] = 32'h1234_5678; c[4] = 32'h1234_5678; end
                default: for (int j = 0; j < 6; j++) c[j] = $urandom;
            endcase
            send_wire(c, segs);
        end

        // Hold off until everything has drained.
        s_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);

        for (int n = 0; n < 500; n++) begin
            if (n == 420) idle_on = 1'b0;
            for (int j = 0; j < 6; j++) c[j] = rand_coord();
            if ($urandom_range(0, 9) == 0)
                for (int j = 0; j < 3; j++) c[j+3] = c[j];   // coincident ends
            segs = ($urandom_range(0, 9) == 0) ? '0 : COUNT_W'($urandom);
            send_wire(c, segs);
        end
        s_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        $display("Sent %0d wires (directed extremes, coincident ends, zero segments, random).",
                 sent);
        $display("Checked %0d result words, %0d failures.", seen, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end
endmodule
